// File: hdl/swts_pkg.sv
// package for the sliding window transfer statistics block
// field widths, csr register indexes, stored record and result types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swts_pkg;

   localparam int SWTS_WINDOW_DEPTH = 64;

   localparam int SIZE_W  = 40;
   localparam int SPEED_W = 34;
   localparam int LAT_W   = 20;
   localparam int FAIL_W  = 16;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 7;
   localparam int PCT_W   = 7;
   localparam int CHUNK_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // default divider sizing for the default window depth
   localparam int SWTS_DIVIDEND_W = 2 * SIZE_W + $clog2(SWTS_WINDOW_DEPTH + 1);
   localparam int SWTS_DIVISOR_W  = SIZE_W + $clog2(SWTS_WINDOW_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_DOWNLOAD = 2'd2;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 7'd64;
   localparam logic [TIME_W-1:0]  MAX_AGE_RST     = 32'd3600;

   typedef struct packed {
      logic [SIZE_W-1:0]  size;
      logic [SPEED_W-1:0] speed;
      logic [LAT_W-1:0]   latency;
      logic [FAIL_W-1:0]  failed;
      logic               raided;
      logic [TIME_W-1:0]  stamp;
   } record_type;

   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] entry_count;
      logic [SIZE_W-1:0]  median_size;
      logic [SIZE_W-1:0]  contraharmonic_size;
      logic [SPEED_W-1:0] median_speed;
      logic [SPEED_W-1:0] weighted_speed;
      logic [SPEED_W-1:0] max_speed;
      logic [LAT_W-1:0]   avg_latency;
      logic [PCT_W-1:0]   failed_percent;
      logic [PCT_W-1:0]   raided_percent;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/sliding_window_transfer_stats.sv
// top level of the sliding window transfer statistics block
// uses swts_pkg, swts_store (record memory) and swts_div (shared divider)
//
//  channel  direction  handshake              carries
//  req_     in         req_valid / req_stall  one add or report item
//  rsp_     out        rsp_valid / rsp_stall  one result item per request
//  csr_     in         csr_valid / csr_ready  register index and write data
//
// one item at a time: req_stall is high from acceptance until the result reaches
// the output register, which holds it under rsp_stall; sync reset empties the window
// add: checks the age of the oldest record, dropping each aged-out one, then trims
// while the window is full and writes the item; a rejected add or an empty report goes to done
// report: sums on the shared 40x20 multiplier, rank selection, five divisions
// (DW = 87 at depth 64) and a finishing step
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_transfer_stats #(
   parameter int WINDOW_DEPTH = swts_pkg::SWTS_WINDOW_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [swts_pkg::TIME_W-1:0]       req_now_seconds,
   input  logic [swts_pkg::SIZE_W-1:0]       req_record_size,
   input  logic [swts_pkg::SPEED_W-1:0]      req_record_speed,
   input  logic [swts_pkg::LAT_W-1:0]        req_record_latency,
   input  logic [swts_pkg::FAIL_W-1:0]       req_failed_ratio,
   input  logic                              req_raided,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic [swts_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic [swts_pkg::SIZE_W-1:0]       rsp_median_size,
   output logic [swts_pkg::SIZE_W-1:0]       rsp_contraharmonic_size,
   output logic [swts_pkg::SPEED_W-1:0]      rsp_median_speed,
   output logic [swts_pkg::SPEED_W-1:0]      rsp_weighted_speed,
   output logic [swts_pkg::SPEED_W-1:0]      rsp_max_speed,
   output logic [swts_pkg::LAT_W-1:0]        rsp_avg_latency,
   output logic [swts_pkg::PCT_W-1:0]        rsp_failed_percent,
   output logic [swts_pkg::PCT_W-1:0]        rsp_raided_percent,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import swts_pkg::*;

   localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW  = $clog2(WINDOW_DEPTH + 1);
   localparam int OW  = CW + 1;
   localparam int LW  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int DW  = 2 * SIZE_W + CW;
   localparam int RW  = SIZE_W + CW;
   localparam int SLW = LAT_W + CW;
   localparam int SFW = FAIL_W + CW;
   localparam int FPW = SFW + 7;
   localparam int RPW = CW + 7;
   localparam int PW  = SIZE_W + CHUNK_W;
   // result bits below accepted and entry_count
   localparam int RES_REST_W = $bits(result_type) - 1 - COUNT_W;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_ADD_RD    = 12'b000000000010,
      ST_ADD_CHK   = 12'b000000000100,
      ST_ADD_TRIM  = 12'b000000001000,
      ST_SUM       = 12'b000000010000,
      ST_SEL_CAND  = 12'b000000100000,
      ST_SEL_LATCH = 12'b000001000000,
      ST_SEL_SCAN  = 12'b000010000000,
      ST_SEL_EVAL  = 12'b000100000000,
      ST_DIV_GO    = 12'b001000000000,
      ST_DIV_WAIT  = 12'b010000000000,
      ST_DONE      = 12'b100000000000
   } state_type;

   typedef enum logic [2:0] {
      DIV_SQ, DIV_WS, DIV_LAT, DIV_FAIL, DIV_RAID
   } div_sel_type;

   // which partial product sits in the product register
   typedef enum logic [1:0] {
      PT_SQ_LO, PT_SQ_HI, PT_WS_LO, PT_WS_HI
   } prod_tag_type;

   state_type state_ff, state_in;

   // configuration and window control
   logic [COUNT_W-1:0] max_entries_ff;
   logic [TIME_W-1:0]  max_age_ff;
   logic               is_download_ff;
   logic [AW-1:0]      oldest_ff;
   logic [CW-1:0]      count_ff;

   // item and walk registers
   record_type         item_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      col_ff;
   logic [2:0]         sub_ff;
   logic [SIZE_W-1:0]  ent_size_ff;
   logic [SPEED_W-1:0] ent_speed_ff;

   // accumulators
   logic [DW-1:0]      acc_sq_ff;
   logic [DW-1:0]      acc_ws_ff;
   logic [RW-1:0]      sum_size_ff;
   logic [SLW-1:0]     sum_lat_ff;
   logic [SFW-1:0]     sum_fail_ff;
   logic [CW-1:0]      raid_cnt_ff;
   logic [SPEED_W-1:0] max_speed_ff;
   logic [PW-1:0]      prod_ff;
   prod_tag_type       prod_tag_ff;
   logic               prod_vld_ff;

   // rank selection
   logic [SIZE_W-1:0]  cand_size_ff;
   logic [SPEED_W-1:0] cand_speed_ff;
   logic [CW-1:0]      lt_size_ff, le_size_ff, lt_speed_ff, le_speed_ff;
   logic [SIZE_W-1:0]  med_size_lo_ff, med_size_hi_ff;
   logic [SPEED_W-1:0] med_speed_lo_ff, med_speed_hi_ff;

   div_sel_type        div_sel_ff;
   result_type         res_ff;
   result_type         out_ff;
   logic               rsp_valid_ff;

   // combinational
   logic               req_accept;
   logic               add_invalid;
   logic [CW-1:0]      last_off;
   logic [CW-1:0]      rd_off;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               wr_en;
   record_type         rd_data;
   logic [LW-1:0]      lim_w;
   logic               trim_needed;
   logic [TIME_W-1:0]  age;
   logic               too_old;
   logic [CW-1:0]      rank_lo, rank_hi;
   logic [CHUNK_W-1:0] mul_b;
   prod_tag_type       mul_tag;
   logic [SIZE_W:0]    med_size_sum;
   logic [SPEED_W:0]   med_speed_sum;
   logic [FPW-1:0]     fail_scaled;
   logic [RPW-1:0]     raid_scaled;
   logic               div_start;
   logic               div_done;
   logic [DW-1:0]      div_dividend;
   logic [RW-1:0]      div_divisor;
   logic [DW-1:0]      div_q;
   logic               out_free;

   // position of a window offset in the circular store
   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [OW-1:0] s;
      s = OW'(base) + OW'(off);
      if (s >= OW'(WINDOW_DEPTH)) begin
         s = s - OW'(WINDOW_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic hit(input logic [CW-1:0] lt, input logic [CW-1:0] le,
                                input logic [CW-1:0] r);
      return (lt <= r) && (r < le);
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign add_invalid = (req_record_size == '0) || (req_record_speed == '0)
                        || (req_record_latency == '0);

   assign last_off = count_ff - CW'(1);
   assign rank_lo  = last_off >> 1;
   assign rank_hi  = count_ff >> 1;

   // entry limit, zero acts as one and anything above the depth as the depth
   always_comb begin
      if (max_entries_ff == '0) begin
         lim_w = LW'(1);
      end else if (LW'(max_entries_ff) > LW'(WINDOW_DEPTH)) begin
         lim_w = LW'(WINDOW_DEPTH);
      end else begin
         lim_w = LW'(max_entries_ff);
      end
   end

   assign trim_needed = LW'(count_ff) >= lim_w;
   assign age         = item_ff.stamp - rd_data.stamp;
   assign too_old     = age > max_age_ff;

   // read offset chosen by the walk in progress
   always_comb begin
      case (state_ff)
         ST_SUM, ST_SEL_CAND: rd_off = idx_ff;
         ST_SEL_SCAN:         rd_off = col_ff + CW'(1);
         default:             rd_off = '0;
      endcase
   end

   assign rd_addr = wrap(oldest_ff, rd_off);
   assign wr_addr = wrap(oldest_ff, count_ff);
   assign wr_en   = (state_ff == ST_ADD_TRIM) && !trim_needed;

   swts_store #(
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // multiplier operand: 20-bit slices of size then speed
   always_comb begin
      case (sub_ff)
         3'd2: begin
            mul_b   = ent_size_ff[CHUNK_W-1:0];
            mul_tag = PT_SQ_LO;
         end
         3'd3: begin
            mul_b   = ent_size_ff[SIZE_W-1:CHUNK_W];
            mul_tag = PT_SQ_HI;
         end
         3'd4: begin
            mul_b   = ent_speed_ff[CHUNK_W-1:0];
            mul_tag = PT_WS_LO;
         end
         3'd5: begin
            mul_b   = CHUNK_W'(ent_speed_ff[SPEED_W-1:CHUNK_W]);
            mul_tag = PT_WS_HI;
         end
         default: begin
            mul_b   = '0;
            mul_tag = PT_SQ_LO;
         end
      endcase
   end

   assign med_size_sum  = {1'b0, med_size_lo_ff} + {1'b0, med_size_hi_ff} + (SIZE_W+1)'(1);
   assign med_speed_sum = {1'b0, med_speed_lo_ff} + {1'b0, med_speed_hi_ff}
                          + (SPEED_W+1)'(1);
   assign fail_scaled   = FPW'(sum_fail_ff) * FPW'(100);
   assign raid_scaled   = RPW'(raid_cnt_ff) * RPW'(100);

   // divider operands per division
   always_comb begin
      case (div_sel_ff)
         DIV_SQ: begin
            div_dividend = acc_sq_ff;
            div_divisor  = sum_size_ff;
         end
         DIV_WS: begin
            div_dividend = acc_ws_ff;
            div_divisor  = sum_size_ff;
         end
         DIV_LAT: begin
            div_dividend = DW'(sum_lat_ff);
            div_divisor  = RW'(count_ff);
         end
         DIV_FAIL: begin
            div_dividend = DW'(fail_scaled);
            div_divisor  = RW'({count_ff, 16'b0});
         end
         DIV_RAID: begin
            div_dividend = DW'(raid_scaled);
            div_divisor  = RW'(count_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = RW'(1);
         end
      endcase
   end

   assign div_start = (state_ff == ST_DIV_GO);

   swts_div #(
      .DW (DW),
      .RW (RW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_REPORT) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SUM;
               end else if (add_invalid) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = (count_ff != '0) ? ST_ADD_RD : ST_ADD_TRIM;
               end
            end
         end
         ST_ADD_RD: state_in = ST_ADD_CHK;
         ST_ADD_CHK: begin
            if (too_old && (last_off != '0)) begin
               state_in = ST_ADD_RD;
            end else begin
               state_in = ST_ADD_TRIM;
            end
         end
         ST_ADD_TRIM: begin
            if (!trim_needed) begin
               state_in = ST_DONE;
            end
         end
         ST_SUM: begin
            if ((sub_ff == 3'd6) && (idx_ff == last_off)) begin
               state_in = ST_SEL_CAND;
            end
         end
         ST_SEL_CAND:  state_in = ST_SEL_LATCH;
         ST_SEL_LATCH: state_in = ST_SEL_SCAN;
         ST_SEL_SCAN: begin
            if (col_ff == last_off) begin
               state_in = ST_SEL_EVAL;
            end
         end
         ST_SEL_EVAL: state_in = (idx_ff == last_off) ? ST_DIV_GO : ST_SEL_CAND;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (div_sel_ff == DIV_RAID) ? ST_DONE : ST_DIV_GO;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_entries_ff <= MAX_ENTRIES_RST;
         max_age_ff     <= MAX_AGE_RST;
         is_download_ff <= 1'b0;
         oldest_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         prod_vld_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_ENTRIES: max_entries_ff <= csr_data[COUNT_W-1:0];
               CSR_MAX_AGE:     max_age_ff     <= csr_data[TIME_W-1:0];
               CSR_IS_DOWNLOAD: is_download_ff <= csr_data[0];
               default: ;
            endcase
         end

         // aged-out or trimmed record leaves from the oldest end
         if (((state_ff == ST_ADD_CHK) && too_old)
             || ((state_ff == ST_ADD_TRIM) && trim_needed)) begin
            oldest_ff <= wrap(oldest_ff, CW'(1));
            count_ff  <= last_off;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end

         prod_vld_ff <= (state_ff == ST_SUM) && (sub_ff >= 3'd2) && (sub_ff <= 3'd5);

         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      // products land in the accumulators in the cycle after the multiply
      if (prod_vld_ff) begin
         case (prod_tag_ff)
            PT_SQ_LO: acc_sq_ff <= acc_sq_ff + DW'(prod_ff);
            PT_SQ_HI: acc_sq_ff <= acc_sq_ff + DW'({prod_ff, {CHUNK_W{1'b0}}});
            PT_WS_LO: acc_ws_ff <= acc_ws_ff + DW'(prod_ff);
            PT_WS_HI: acc_ws_ff <= acc_ws_ff + DW'({prod_ff, {CHUNK_W{1'b0}}});
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_ff.size    <= req_record_size;
               item_ff.speed   <= req_record_speed;
               item_ff.latency <= req_record_latency;
               item_ff.failed  <= req_failed_ratio;
               item_ff.raided  <= req_raided;
               item_ff.stamp   <= req_now_seconds;
               // statistics start at zero, only accepted and count are known yet
               res_ff       <= {(req_mode == MODE_REPORT) && (count_ff != '0),
                                COUNT_W'(count_ff), {RES_REST_W{1'b0}}};
               acc_sq_ff    <= '0;
               acc_ws_ff    <= '0;
               sum_size_ff  <= '0;
               sum_lat_ff   <= '0;
               sum_fail_ff  <= '0;
               raid_cnt_ff  <= '0;
               max_speed_ff <= '0;
               idx_ff       <= '0;
               sub_ff       <= '0;
            end
         end
         ST_ADD_TRIM: begin
            if (!trim_needed) begin
               res_ff.accepted    <= 1'b1;
               res_ff.entry_count <= COUNT_W'(count_ff + CW'(1));
            end
         end
         ST_SUM: begin
            if (sub_ff == 3'd1) begin
               ent_size_ff  <= rd_data.size;
               ent_speed_ff <= rd_data.speed;
               sum_size_ff  <= sum_size_ff + RW'(rd_data.size);
               sum_lat_ff   <= sum_lat_ff + SLW'(rd_data.latency);
               sum_fail_ff  <= sum_fail_ff + SFW'(rd_data.failed);
               raid_cnt_ff  <= raid_cnt_ff + CW'(rd_data.raided);
               if (rd_data.speed > max_speed_ff) begin
                  max_speed_ff <= rd_data.speed;
               end
            end
            prod_ff     <= PW'(ent_size_ff) * PW'(mul_b);
            prod_tag_ff <= mul_tag;
            if (sub_ff == 3'd6) begin
               sub_ff <= '0;
               idx_ff <= (idx_ff == last_off) ? '0 : idx_ff + CW'(1);
            end else begin
               sub_ff <= sub_ff + 3'd1;
            end
         end
         ST_SEL_LATCH: begin
            cand_size_ff  <= rd_data.size;
            cand_speed_ff <= rd_data.speed;
            lt_size_ff    <= '0;
            le_size_ff    <= '0;
            lt_speed_ff   <= '0;
            le_speed_ff   <= '0;
            col_ff        <= '0;
         end
         ST_SEL_SCAN: begin
            lt_size_ff  <= lt_size_ff + CW'(rd_data.size < cand_size_ff);
            le_size_ff  <= le_size_ff + CW'(rd_data.size <= cand_size_ff);
            lt_speed_ff <= lt_speed_ff + CW'(rd_data.speed < cand_speed_ff);
            le_speed_ff <= le_speed_ff + CW'(rd_data.speed <= cand_speed_ff);
            col_ff      <= col_ff + CW'(1);
         end
         ST_SEL_EVAL: begin
            // candidate covers ranks lt .. le-1 in sorted order
            if (hit(lt_size_ff, le_size_ff, rank_lo)) begin
               med_size_lo_ff <= cand_size_ff;
            end
            if (hit(lt_size_ff, le_size_ff, rank_hi)) begin
               med_size_hi_ff <= cand_size_ff;
            end
            if (hit(lt_speed_ff, le_speed_ff, rank_lo)) begin
               med_speed_lo_ff <= cand_speed_ff;
            end
            if (hit(lt_speed_ff, le_speed_ff, rank_hi)) begin
               med_speed_hi_ff <= cand_speed_ff;
            end
            idx_ff     <= idx_ff + CW'(1);
            div_sel_ff <= DIV_SQ;
         end
         ST_DIV_GO: begin
            res_ff.median_size  <= med_size_sum[SIZE_W:1];
            res_ff.median_speed <= med_speed_sum[SPEED_W:1];
            res_ff.max_speed    <= max_speed_ff;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (div_sel_ff)
                  DIV_SQ: begin
                     res_ff.contraharmonic_size <= div_q[SIZE_W-1:0];
                     div_sel_ff                 <= DIV_WS;
                  end
                  DIV_WS: begin
                     res_ff.weighted_speed <= div_q[SPEED_W-1:0];
                     div_sel_ff            <= DIV_LAT;
                  end
                  DIV_LAT: begin
                     res_ff.avg_latency <= div_q[LAT_W-1:0];
                     div_sel_ff         <= DIV_FAIL;
                  end
                  DIV_FAIL: begin
                     res_ff.failed_percent <= div_q[PCT_W-1:0];
                     div_sel_ff            <= DIV_RAID;
                  end
                  DIV_RAID: begin
                     res_ff.raided_percent <= is_download_ff ? div_q[PCT_W-1:0] : '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_ff <= res_ff;
            end
         end
         default: ;
      endcase

      if (state_ff == ST_SEL_CAND) begin
         col_ff <= '0;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_accepted            = out_ff.accepted;
   assign rsp_entry_count         = out_ff.entry_count;
   assign rsp_median_size         = out_ff.median_size;
   assign rsp_contraharmonic_size = out_ff.contraharmonic_size;
   assign rsp_median_speed        = out_ff.median_speed;
   assign rsp_weighted_speed      = out_ff.weighted_speed;
   assign rsp_max_speed           = out_ff.max_speed;
   assign rsp_avg_latency         = out_ff.avg_latency;
   assign rsp_failed_percent      = out_ff.failed_percent;
   assign rsp_raided_percent      = out_ff.raided_percent;

endmodule

`default_nettype wire

// File: hdl/swts_store.sv
// record store: one write port, one registered read port
// depends on swts_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module swts_store #(
   parameter int DEPTH = swts_pkg::SWTS_WINDOW_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  swts_pkg::record_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output swts_pkg::record_type rd_data
);
   import swts_pkg::*;

   record_type mem_ff [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/swts_div.sv
// shared restoring divider, one quotient bit a cycle, round half up at the end
// no package dependencies beyond default sizing from swts_pkg
`timescale 1ns / 1ps
`default_nettype none

module swts_div #(
   parameter int DW = swts_pkg::SWTS_DIVIDEND_W,
   parameter int RW = swts_pkg::SWTS_DIVISOR_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int NW = $clog2(DW + 1);

   logic          busy_ff;
   logic          rnd_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] den_ff;
   logic [DW-1:0] quo_ff;

   logic [RW:0] rem_sh;
   logic [RW:0] rem_diff;
   logic        ge;
   logic        round_up;

   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign ge       = rem_sh >= {1'b0, den_ff};
   assign round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + NW'(1);
            if (cnt_ff == NW'(DW - 1)) begin
               busy_ff <= 1'b0;
               rnd_ff  <= 1'b1;
            end
         end else if (rnd_ff) begin
            rnd_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end else if (rnd_ff) begin
         quo_ff <= quo_ff + DW'(round_up);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
